[rtl/psmd_pkg.sv]
package psmd_pkg;

    // Field and register widths.
    localparam int POSITION_BITS = 10;
    localparam int SETPOINT_W    = 10;
    localparam int GAIN_W        = 16;
    localparam int DB_W          = 8;
    localparam int DUTY_W        = 8;
    localparam int DV_W          = 16;
    localparam int INTEG_W       = 16;
    localparam int FRAC_W        = 12;

    // Datapath widths, all derived from the field widths.
    localparam int E_W      = ((POSITION_BITS > SETPOINT_W) ? POSITION_BITS : SETPOINT_W) + 1;
    localparam int DIFF_W   = E_W + 1;
    localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int ISUM_W   = ((INTEG_W + FRAC_W > PROD_W) ? INTEG_W + FRAC_W : PROD_W) + 1;
    localparam int ITRUNC_W = ISUM_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 2;
    localparam int X_W      = SUM_W + 2;
    localparam int Q_W      = X_W - 2;
    localparam int RECIP_K  = X_W + 3;
    localparam int RECIP_W  = X_W + 1;
    localparam int RPROD_W  = 2 * X_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_K) / 64'd5);

    localparam int INTEG_MAX = 2 ** (INTEG_W - 1) - 1;
    localparam int DV_MAX    = 2 ** (DV_W - 1) - 1;

    // Stream widths.
    localparam int IN_TDATA_W   = ((POSITION_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + DUTY_W + DV_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX  = 3'd5;

    localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 10'd100;
    localparam logic [GAIN_W-1:0]     GAIN_P_RST   = 16'd4096;
    localparam logic [GAIN_W-1:0]     GAIN_I_RST   = 16'd205;
    localparam logic [GAIN_W-1:0]     GAIN_D_RST   = 16'd2867;
    localparam logic [DB_W-1:0]       DEADBAND_RST = 8'd5;
    localparam logic [DUTY_W-1:0]     PWM_MAX_RST  = 8'd255;

    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint;
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [DB_W-1:0]       deadband;
        logic [DUTY_W-1:0]     pwm_max;
    } cfg_t;

    // One enable per datapath step, issued by the controller.
    typedef struct packed {
        logic load;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic sum;
        logic scale;
        logic recip;
        logic fix;
        logic decide;
    } cmd_t;

endpackage

[rtl/psmd_ctrl.sv]
module psmd_ctrl
    import psmd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic out_busy,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MP     = 4'd1;
    localparam logic [3:0] ST_MI     = 4'd2;
    localparam logic [3:0] ST_MD     = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_SCALE  = 4'd5;
    localparam logic [3:0] ST_RECIP  = 4'd6;
    localparam logic [3:0] ST_FIX    = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MP;
                end
            end
            ST_MP: begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MI;
            end
            ST_MI: begin
                cmd.mul_i  = 1'b1;
                state_next = ST_MD;
            end
            ST_MD: begin
                cmd.mul_d  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // Wait here until the previous result has left the output register.
                if (!out_busy) begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MP))
        else $error("accepted request did not start the multiply sequence");

    a_decide_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> !out_busy)
        else $error("result written while output register still occupied");

    a_fix_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fix |=> (state_reg == ST_DECIDE))
        else $error("sequence skipped the decision step");

endmodule

[rtl/psmd_datapath.sv]
module psmd_datapath
    import psmd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  cmd_t                     cmd,
    input  logic [POSITION_BITS-1:0] position,
    output logic                     out_busy,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic                     forward,
    output logic                     reverse,
    output logic [DUTY_W-1:0]        duty,
    output logic signed [DV_W-1:0]   drive_value,
    output logic                     held
);

    // Controller state carried between requests.
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [E_W-1:0]     prev_err_reg;
    logic                      last_fwd_reg;
    logic                      last_rev_reg;
    logic [DUTY_W-1:0]         last_duty_reg;
    logic                      valid_reg;

    // Per-request working registers.
    logic signed [E_W-1:0]    e_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TERM_W-1:0] p_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg;
    logic [X_W-1:0]           x_reg;
    logic [Q_W-1:0]           qe_reg;
    logic [Q_W-1:0]           q_reg;
    logic signed [DV_W-1:0]   dv_reg;
    logic                     held_reg;

    logic signed [E_W-1:0]    e_next;
    logic signed [GAIN_W:0]   mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [TERM_W-1:0] term_trunc;
    logic signed [ISUM_W-1:0] isum;
    logic signed [ISUM_W-1:0] isum_adj;
    logic signed [ITRUNC_W-1:0] itrunc;
    logic signed [INTEG_W-1:0]  integral_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           sum_mag;
    logic [SUM_W+5:0]           x51;
    logic [RPROD_W-1:0]         rprod;
    logic [X_W-1:0]             rem;
    logic [Q_W-1:0]             db_ext;
    logic [Q_W-1:0]             pmax_ext;
    logic                       mag_over;
    logic [DUTY_W-1:0]          duty_sat;
    logic signed [DV_W-1:0]     dv_sat;

    assign e_next = E_W'(position) - E_W'(cfg.setpoint);

    // Shared gain multiplier: unsigned Q4.12 gain times a signed error term.
    always_comb begin
        mul_a = signed'({1'b0, cfg.gain_p});
        mul_b = DIFF_W'(e_reg);
        if (cmd.mul_i) begin
            mul_a = signed'({1'b0, cfg.gain_i});
        end else if (cmd.mul_d) begin
            mul_a = signed'({1'b0, cfg.gain_d});
            mul_b = diff_reg;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Truncation toward zero: a negative value is biased by 2^12-1 before the shift.
    assign prod_adj   = prod_reg + PROD_W'({FRAC_W{prod_reg[PROD_W-1]}});
    assign term_trunc = prod_adj[PROD_W-1:FRAC_W];

    assign isum     = ISUM_W'(signed'({integral_reg, {FRAC_W{1'b0}}})) + ISUM_W'(prod_reg);
    assign isum_adj = isum + ISUM_W'({FRAC_W{isum[ISUM_W-1]}});
    assign itrunc   = isum_adj[ISUM_W-1:FRAC_W];

    always_comb begin
        if (itrunc > ITRUNC_W'(INTEG_MAX)) begin
            integral_next = INTEG_W'(INTEG_MAX);
        end else if (itrunc < ITRUNC_W'(-INTEG_MAX)) begin
            integral_next = INTEG_W'(-INTEG_MAX);
        end else begin
            integral_next = itrunc[INTEG_W-1:0];
        end
    end

    assign sum_next = SUM_W'(p_reg) + SUM_W'(integral_reg) + SUM_W'(term_trunc);

    // |sum| * 51 / 16 by shift and add; the division by 5 follows by reciprocal.
    assign sum_mag = SUM_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);
    assign x51 = ((SUM_W+6)'(sum_mag) << 5) + ((SUM_W+6)'(sum_mag) << 4)
               + ((SUM_W+6)'(sum_mag) << 1) + (SUM_W+6)'(sum_mag);

    assign rprod = RPROD_W'(x_reg) * RPROD_W'(RECIP_M);

    // The reciprocal estimate is exact or one low; the remainder decides.
    assign rem = x_reg - (X_W'({qe_reg, 2'b00}) + X_W'(qe_reg));

    assign db_ext   = Q_W'(cfg.deadband);
    assign pmax_ext = Q_W'(cfg.pwm_max);
    assign mag_over = (q_reg > pmax_ext);
    assign duty_sat = mag_over ? cfg.pwm_max : q_reg[DUTY_W-1:0];

    always_comb begin
        if (neg_reg) begin
            dv_sat = (q_reg > Q_W'(DV_MAX + 1)) ? DV_W'(-DV_MAX - 1) : -signed'(q_reg[DV_W-1:0]);
        end else begin
            dv_sat = (q_reg > Q_W'(DV_MAX)) ? DV_W'(DV_MAX) : signed'(q_reg[DV_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            e_reg <= e_next;
        end
        if (cmd.mul_p) begin
            diff_reg <= DIFF_W'(e_reg) - DIFF_W'(prev_err_reg);
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d) begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_i) begin
            p_reg <= term_trunc;
        end
        if (cmd.sum) begin
            sum_reg <= sum_next;
        end
        if (cmd.scale) begin
            x_reg   <= x51[SUM_W+5:4];
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.recip) begin
            qe_reg <= rprod[RECIP_K+Q_W-1:RECIP_K];
        end
        if (cmd.fix) begin
            q_reg <= qe_reg + Q_W'(rem >= X_W'(5));
        end
        if (cmd.decide) begin
            dv_reg   <= dv_sat;
            held_reg <= (q_reg == db_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            last_fwd_reg  <= 1'b0;
            last_rev_reg  <= 1'b0;
            last_duty_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (cmd.mul_p) begin
                prev_err_reg <= e_reg;
            end
            if (cmd.mul_d) begin
                integral_reg <= integral_next;
            end
            if (cmd.decide) begin
                valid_reg <= 1'b1;
                // On the deadband edge the previous direction and duty are kept.
                if (q_reg != db_ext) begin
                    if (q_reg > db_ext) begin
                        last_fwd_reg  <= !neg_reg;
                        last_rev_reg  <= neg_reg;
                        last_duty_reg <= duty_sat;
                    end else begin
                        last_fwd_reg  <= 1'b0;
                        last_rev_reg  <= 1'b0;
                        last_duty_reg <= '0;
                    end
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_busy    = valid_reg && !m_tready;
    assign m_tvalid    = valid_reg;
    assign forward     = last_fwd_reg;
    assign reverse     = last_rev_reg;
    assign duty        = last_duty_reg;
    assign drive_value = dv_reg;
    assign held        = held_reg;

    a_dir_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(last_fwd_reg && last_rev_reg))
        else $error("forward and reverse driven together");

    a_valid_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(cmd.decide))
        else $error("result appeared without a decision step");

    a_integral_range: assert property (@(posedge aclk) disable iff (!aresetn)
        integral_reg != INTEG_W'(-INTEG_MAX - 1))
        else $error("integral left its saturation range");

endmodule

[rtl/pid_steer_motor_drive.sv]
// Requests are accepted only in idle, once the last has passed its decide step, which
// waits for a pending result to be taken; the three gain products share one multiplier
// and the divide by 80 takes a scale, a reciprocal multiply and a correction step.
// Reset: aresetn is synchronous and active low; it clears the integral, the previous
// error and the last direction and duty, and loads the default register values.
module pid_steer_motor_drive
    import psmd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // position
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // forward, reverse, duty, drive_value
    output logic                   m_tuser    // held
);

    cfg_t cfg_reg;
    cmd_t cmd;
    logic out_busy;

    logic                   forward;
    logic                   reverse;
    logic [DUTY_W-1:0]      duty;
    logic signed [DV_W-1:0] drive_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint <= SETPOINT_RST;
            cfg_reg.gain_p   <= GAIN_P_RST;
            cfg_reg.gain_i   <= GAIN_I_RST;
            cfg_reg.gain_d   <= GAIN_D_RST;
            cfg_reg.deadband <= DEADBAND_RST;
            cfg_reg.pwm_max  <= PWM_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETPOINT: cfg_reg.setpoint <= cfg_data[SETPOINT_W-1:0];
                REG_GAIN_P:   cfg_reg.gain_p   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   cfg_reg.gain_i   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   cfg_reg.gain_d   <= cfg_data[GAIN_W-1:0];
                REG_DEADBAND: cfg_reg.deadband <= cfg_data[DB_W-1:0];
                REG_PWM_MAX:  cfg_reg.pwm_max  <= cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    psmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_busy (out_busy),
        .cmd      (cmd)
    );

    psmd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .position    (s_tdata[POSITION_BITS-1:0]),
        .out_busy    (out_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .forward     (forward),
        .reverse     (reverse),
        .duty        (duty),
        .drive_value (drive_value),
        .held        (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({drive_value, duty, reverse, forward});

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import psmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 400;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 145;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_RARE,
        READY_SQUARE
    } ready_mode_t;

    typedef struct {
        logic                   forward;
        logic                   reverse;
        logic [DUTY_W-1:0]      duty;
        logic signed [DV_W-1:0] drive_value;
        logic                   held;
    } motor_cmd_t;

    // Tracks the controller state and queues the motor command each request should produce.
    class pid_drive_tracker;
        logic [SETPOINT_W-1:0]     setpoint;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [DB_W-1:0]           deadband;
        logic [DUTY_W-1:0]         pwm_max;
        logic signed [INTEG_W-1:0] integral;
        logic signed [E_W-1:0]     prev_error;
        logic                      last_forward;
        logic                      last_reverse;
        logic [DUTY_W-1:0]         last_duty;
        motor_cmd_t                pending_cmds[$];
        int                        fail_count;

        function new();
            setpoint     = SETPOINT_RST;
            gain_p       = GAIN_P_RST;
            gain_i       = GAIN_I_RST;
            gain_d       = GAIN_D_RST;
            deadband     = DEADBAND_RST;
            pwm_max      = PWM_MAX_RST;
            integral     = '0;
            prev_error   = '0;
            last_forward = 1'b0;
            last_reverse = 1'b0;
            last_duty    = '0;
            fail_count   = 0;
        endfunction

        function void note_failure(string msg);
            if (fail_count < 10) $display("[%0t] %s", $realtime, msg);
            fail_count++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SETPOINT: setpoint = data[SETPOINT_W-1:0];
                REG_GAIN_P:   gain_p   = data[GAIN_W-1:0];
                REG_GAIN_I:   gain_i   = data[GAIN_W-1:0];
                REG_GAIN_D:   gain_d   = data[GAIN_W-1:0];
                REG_DEADBAND: deadband = data[DB_W-1:0];
                REG_PWM_MAX:  pwm_max  = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_position(logic [POSITION_BITS-1:0] pos);
            longint     err, p_term, i_new, d_term, total, drive, db, mag;
            motor_cmd_t cmd;
            err    = longint'(pos) - longint'(setpoint);
            p_term = (longint'(gain_p) * err) / 4096;
            i_new  = (longint'(integral) * 4096 + longint'(gain_i) * err) / 4096;
            d_term = (longint'(gain_d) * (err - longint'(prev_error))) / 4096;
            if (i_new > longint'(INTEG_MAX)) i_new = longint'(INTEG_MAX);
            if (i_new < longint'(-INTEG_MAX)) i_new = longint'(-INTEG_MAX);
            integral   = INTEG_W'(i_new);
            prev_error = E_W'(err);
            total = p_term + i_new + d_term;
            drive = (total * 51) / 80;
            db    = longint'(deadband);
            cmd.held = 1'b0;
            // A drive sitting exactly on the deadband edge repeats the last command.
            if (drive == db || drive == -db) begin
                cmd.forward = last_forward;
                cmd.reverse = last_reverse;
                cmd.duty    = last_duty;
                cmd.held    = 1'b1;
            end else if (drive < -db) begin
                mag = -drive;
                cmd.forward = 1'b0;
                cmd.reverse = 1'b1;
                cmd.duty    = (mag > longint'(pwm_max)) ? pwm_max : DUTY_W'(mag);
            end else if (drive > db) begin
                cmd.forward = 1'b1;
                cmd.reverse = 1'b0;
                cmd.duty    = (drive > longint'(pwm_max)) ? pwm_max : DUTY_W'(drive);
            end else begin
                cmd.forward = 1'b0;
                cmd.reverse = 1'b0;
                cmd.duty    = '0;
            end
            last_forward = cmd.forward;
            last_reverse = cmd.reverse;
            last_duty    = cmd.duty;
            if (drive > longint'(DV_MAX)) drive = longint'(DV_MAX);
            if (drive < longint'(-DV_MAX - 1)) drive = longint'(-DV_MAX - 1);
            cmd.drive_value = DV_W'(drive);
            pending_cmds.push_back(cmd);
        endfunction

        function void check_drive(logic [OUT_TDATA_W-1:0] data, logic user);
            motor_cmd_t want, got;
            got.forward     = data[0];
            got.reverse     = data[1];
            got.duty        = data[2 +: DUTY_W];
            got.drive_value = data[2 + DUTY_W +: DV_W];
            got.held        = user;
            if (pending_cmds.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result: fwd=%0d rev=%0d duty=%0d drive=%0d held=%0d",
                    got.forward, got.reverse, got.duty, got.drive_value, got.held));
                return;
            end
            want = pending_cmds.pop_front();
            if (got.forward !== want.forward || got.reverse !== want.reverse ||
                got.duty !== want.duty || got.drive_value !== want.drive_value ||
                got.held !== want.held) begin
                note_failure($sformatf({
                    "mismatch: expected fwd=%0d rev=%0d duty=%0d drive=%0d held=%0d,",
                    " got fwd=%0d rev=%0d duty=%0d drive=%0d held=%0d"},
                    want.forward, want.reverse, want.duty, want.drive_value, want.held,
                    got.forward, got.reverse, got.duty, got.drive_value, got.held));
            end
        endfunction

        function void finish_check();
            if (pending_cmds.size() != 0)
                note_failure($sformatf("%0d results never arrived", pending_cmds.size()));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    pid_drive_tracker tracker;
    logic             want_long_stall = 1'b0;
    int               quiet_cycles = 0;
    int               burst_left = 0;

    pid_steer_motor_drive dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Monitor and watchdog. Results are checked before the same edge's request is noted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_drive(m_tdata, m_tuser);
        if (aresetn && s_tvalid && s_tready) tracker.take_position(s_tdata[POSITION_BITS-1:0]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pid_steer_motor_drive regression: fail");
            $finish;
        end
    end

    // Receiver: switches between ready patterns, and on request holds off for a long stretch.
    initial begin
        ready_mode_t mode;
        int          mode_left;
        int          tick;
        m_tready  = 1'b0;
        mode      = READY_ALWAYS;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            if (want_long_stall) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                want_long_stall = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 4));
                    mode_left = $urandom_range(64, 512);
                end
                mode_left--;
                tick++;
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    READY_RARE:   m_tready <= ($urandom_range(0, 7) == 0);
                    default:      m_tready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] sp, kp, ki, kd, db, pmax);
        cfg_write(REG_SETPOINT, sp);
        cfg_write(REG_GAIN_P, kp);
        cfg_write(REG_GAIN_I, ki);
        cfg_write(REG_GAIN_D, kd);
        cfg_write(REG_DEADBAND, db);
        cfg_write(REG_PWM_MAX, pmax);
        cfg_close();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg(logic [CFG_DATA_W-1:0] rst);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return rst;
            3:       return CFG_DATA_W'($urandom_range(0, 31));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Many positions close to the setpoint, where the deadband decisions happen.
    function automatic logic [POSITION_BITS-1:0] pick_position();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = int'(tracker.setpoint) + $urandom_range(0, 24) - 12;
                if (v < 0) v = 0;
                if (v > 2 ** POSITION_BITS - 1) v = 2 ** POSITION_BITS - 1;
                return POSITION_BITS'(v);
            end
            4:       return '0;
            5:       return '1;
            default: return POSITION_BITS'($urandom);
        endcase
    endfunction

    task automatic send_position(input logic [POSITION_BITS-1:0] pos);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(pos);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends requests in bursts separated by short gaps, with an occasional long unbroken run.
    task automatic send_burst(input logic [POSITION_BITS-1:0] pos);
        send_position(pos);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_list(input logic [POSITION_BITS-1:0] list[$]);
        foreach (list[i]) send_burst(list[i]);
        wait_drained();
    endtask

    initial begin
        tracker   = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = 4;

        // Pure proportional control: error 8 maps to drive 5, right on the deadband edge.
        set_regs(100, 4096, 0, 0, 5, 255);
        send_list('{100, 108, 92, 0, 108, 1023, 92, 100});

        // Zero deadband holds on a zero drive; zero pwm_max clamps the duty to nothing.
        set_regs(100, 4096, 0, 0, 0, 0);
        send_list('{100, 101, 102, 98});

        // Full gains drive the integral and the drive value into saturation both ways.
        set_regs(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255);
        send_list('{1023, 1023, 1023, 0, 1023});
        set_regs(1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255);
        send_list('{0, 0, 0, 1023});

        // Zero gains leave the saturated integral alone; spare indexes must change nothing.
        cfg_write(REG_SPARE_A, 16'hFFFF);
        cfg_write(REG_SPARE_B, 16'h0000);
        set_regs(16'hFE00, 0, 0, 0, 16'hFF00, 16'h0080);
        send_list('{512, 0, 1023});

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cfg_write(REG_SETPOINT, pick_reg(SETPOINT_RST));
            cfg_write(REG_GAIN_P, pick_reg(GAIN_P_RST));
            cfg_write(REG_GAIN_I, pick_reg(GAIN_I_RST));
            cfg_write(REG_GAIN_D, pick_reg(GAIN_D_RST));
            cfg_write(REG_DEADBAND, pick_reg(DEADBAND_RST));
            cfg_write(REG_PWM_MAX, pick_reg(PWM_MAX_RST));
            if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
            cfg_close();
            // Two phases back up the pipeline against a long receiver hold-off.
            if (ph == 2 || ph == 7) want_long_stall = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_burst(pick_position());
            wait_drained();
        end

        while (tracker.pending_cmds.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        tracker.finish_check();
        if (tracker.fail_count == 0) begin
            $display("pid_steer_motor_drive regression: pass");
        end else begin
            $display("pid_steer_motor_drive regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/psmd_pkg.sv
rtl/psmd_ctrl.sv
rtl/psmd_datapath.sv
rtl/pid_steer_motor_drive.sv
tb/sv/testbench.sv
